// ----- rtl/mtkm_pkg.sv -----
package mtkm_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes of a result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // result kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // key layout
    localparam int         KEY_W      = 11;
    localparam int         ID_W       = 8;
    localparam int         QUO_W      = 10;
    localparam int         BIT_W      = 4;
    localparam logic [10:0] KEY_OFFSET = 11'd768;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last_pixel;
        logic [7:0] tile_id;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  matched_tile;
        logic [10:0] key_value;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_INS_RD,
        S_INS_CMP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PICK_WAIT,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/mtkm_ram.sv -----
module mtkm_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mosaic_tile_key_matcher.sv -----
// Mosaic tile key matcher.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes tile pixels, query
// pixels and clear commands. Output channel (o_out_valid / i_out_ready /
// o_out_word) returns one word per finished tile load and per query.
// A non-final tile pixel and a clear give no word.
// A final tile pixel runs a 10-step restoring divider for the mean key, then
// an insertion pass through the sorted table RAM that moves each larger
// entry up by one place; on a full table the insertion is skipped and the
// result word reports a full status.
// A query runs a binary search over the table, each probe a RAM read state
// and a compare state due to the registered RAM read; on an empty table it
// goes straight to the result.
// The table RAM has a single read port; the block takes a new word only
// when idle, one word at a time.
// A finished result waits in the output register; the next word is taken
// while it waits, and a later result holds in the sequencer until the
// receiver takes the earlier one.
// Reset empties the table and clears the tile accumulators; table RAM
// contents are not cleared and need no clearing pass.
module mosaic_tile_key_matcher #(
    parameter int TABLE_ENTRIES   = 256,
    parameter int MAX_TILE_PIXELS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mtkm_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mtkm_pkg::t_out_word   o_out_word
);

    localparam int     AW     = $clog2(TABLE_ENTRIES);
    localparam int     TCW    = $clog2(TABLE_ENTRIES + 1);
    localparam longint MAXSUM = 64'(765) * 64'(MAX_TILE_PIXELS);
    localparam int     SUM_W  = $clog2(MAXSUM + 1);
    localparam int     CNT_W  = $clog2(MAX_TILE_PIXELS + 1);
    localparam int     DW     = SUM_W + mtkm_pkg::QUO_W;
    localparam int     RW     = mtkm_pkg::KEY_W + mtkm_pkg::ID_W;

    mtkm_pkg::t_state    r_state, n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [TCW-1:0]      r_entries;
    logic [DW-1:0]       r_rem, r_dsh;
    logic [mtkm_pkg::QUO_W-1:0] r_quo;
    logic [mtkm_pkg::BIT_W-1:0] r_bit;
    logic                r_div_zero;
    logic [mtkm_pkg::KEY_W-1:0] r_key;
    logic [mtkm_pkg::ID_W-1:0]  r_id;
    logic [TCW-1:0]      r_pos, r_lo, r_hi;
    mtkm_pkg::t_out_word r_res;
    mtkm_pkg::t_out_word r_out;
    logic                r_out_valid;

    logic                in_acc;
    logic                out_free;
    logic [9:0]          pix_sum;
    logic                pix_take;
    logic [SUM_W-1:0]    sum_now;
    logic [CNT_W-1:0]    cnt_now;
    logic                div_ge;
    logic [mtkm_pkg::QUO_W-1:0] quo_step;
    logic [TCW-1:0]      mid;
    logic [TCW-1:0]      pick_idx;
    logic [mtkm_pkg::KEY_W-1:0] q_key;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [RW-1:0]       ram_wdata, ram_rdata;
    logic [mtkm_pkg::KEY_W-1:0] rd_key;
    logic                rd_gt;

    function automatic logic [mtkm_pkg::KEY_W-1:0] KEY_W_ext(input logic [9:0] v);
        KEY_W_ext = mtkm_pkg::KEY_OFFSET + mtkm_pkg::KEY_W'(v);
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == mtkm_pkg::S_IDLE);

    // pixel accumulation values
    assign pix_sum  = 10'(i_in_word.blue) + 10'(i_in_word.green) + 10'(i_in_word.red);
    assign pix_take = (r_cnt < CNT_W'(MAX_TILE_PIXELS));
    assign sum_now  = pix_take ? r_sum + SUM_W'(pix_sum) : r_sum;
    assign cnt_now  = pix_take ? r_cnt + CNT_W'(1) : r_cnt;

    // shared divider step
    assign div_ge   = (r_rem >= r_dsh);
    assign quo_step = {r_quo[mtkm_pkg::QUO_W-2:0], div_ge};

    // search helpers
    assign mid      = TCW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign pick_idx = (r_lo != '0 && r_lo < r_entries) ? r_lo - TCW'(1)
                                                       : r_entries - TCW'(1);
    assign q_key    = KEY_W_ext(pix_sum);
    assign rd_key   = ram_rdata[RW-1:mtkm_pkg::ID_W];
    assign rd_gt    = (rd_key > r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtkm_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.operation)
                        mtkm_pkg::OP_PIXEL: begin
                            if (i_in_word.last_pixel) n_state = mtkm_pkg::S_DIV;
                        end
                        mtkm_pkg::OP_QUERY: begin
                            n_state = (r_entries == '0) ? mtkm_pkg::S_EMIT
                                                        : mtkm_pkg::S_SRCH_RD;
                        end
                        default: n_state = mtkm_pkg::S_IDLE;
                    endcase
                end
            end
            mtkm_pkg::S_DIV: begin
                if (r_bit == '0) begin
                    n_state = (r_entries >= TCW'(TABLE_ENTRIES)) ? mtkm_pkg::S_EMIT
                                                                : mtkm_pkg::S_INS_RD;
                end
            end
            mtkm_pkg::S_INS_RD: begin
                n_state = (r_pos == '0) ? mtkm_pkg::S_EMIT : mtkm_pkg::S_INS_CMP;
            end
            mtkm_pkg::S_INS_CMP: begin
                n_state = rd_gt ? mtkm_pkg::S_INS_RD : mtkm_pkg::S_EMIT;
            end
            mtkm_pkg::S_SRCH_RD: begin
                n_state = (r_lo < r_hi) ? mtkm_pkg::S_SRCH_CMP : mtkm_pkg::S_PICK_WAIT;
            end
            mtkm_pkg::S_SRCH_CMP:  n_state = mtkm_pkg::S_SRCH_RD;
            mtkm_pkg::S_PICK_WAIT: n_state = mtkm_pkg::S_EMIT;
            mtkm_pkg::S_EMIT: begin
                if (out_free) n_state = mtkm_pkg::S_IDLE;
            end
            default: n_state = mtkm_pkg::S_IDLE;
        endcase
    end

    // table ram controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = {r_key, r_id};
        ram_raddr = '0;
        case (r_state)
            mtkm_pkg::S_INS_RD: begin
                ram_raddr = AW'(r_pos - TCW'(1));
                if (r_pos == '0) ram_we = 1'b1;
            end
            mtkm_pkg::S_INS_CMP: begin
                ram_we = 1'b1;
                if (rd_gt) ram_wdata = ram_rdata;
            end
            mtkm_pkg::S_SRCH_RD: begin
                ram_raddr = (r_lo < r_hi) ? mid[AW-1:0] : pick_idx[AW-1:0];
            end
            default: ram_raddr = '0;
        endcase
    end

    mtkm_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtkm_pkg::S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_in_word.operation == mtkm_pkg::OP_PIXEL) begin
                if (i_in_word.last_pixel) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= sum_now;
                    r_cnt <= cnt_now;
                end
            end
            if (in_acc && i_in_word.operation == mtkm_pkg::OP_CLEAR) begin
                r_entries <= '0;
            end
            if ((r_state == mtkm_pkg::S_INS_RD && r_pos == '0) ||
                (r_state == mtkm_pkg::S_INS_CMP && !rd_gt)) begin
                r_entries <= r_entries + TCW'(1);
            end
            if (r_state == mtkm_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mtkm_pkg::S_IDLE: begin
                if (in_acc && i_in_word.operation == mtkm_pkg::OP_PIXEL) begin
                    r_rem      <= DW'(sum_now);
                    r_dsh      <= DW'(cnt_now) << (mtkm_pkg::QUO_W - 1);
                    r_quo      <= '0;
                    r_bit      <= mtkm_pkg::BIT_W'(mtkm_pkg::QUO_W - 1);
                    r_div_zero <= (cnt_now == '0);
                    r_id       <= i_in_word.tile_id;
                    r_pos      <= r_entries;
                end
                if (in_acc && i_in_word.operation == mtkm_pkg::OP_QUERY) begin
                    r_key <= q_key;
                    r_lo  <= '0;
                    r_hi  <= r_entries;
                    r_res <= '{result_kind: mtkm_pkg::KIND_QUERY, matched_tile: '0,
                               key_value: q_key,
                               status: (r_entries == '0) ? mtkm_pkg::ST_EMPTY
                                                         : mtkm_pkg::ST_OK};
                end
            end
            mtkm_pkg::S_DIV: begin
                if (div_ge) r_rem <= r_rem - r_dsh;
                r_dsh <= r_dsh >> 1;
                r_quo <= quo_step;
                r_bit <= r_bit - mtkm_pkg::BIT_W'(1);
                if (r_bit == '0) begin
                    r_key <= r_div_zero ? mtkm_pkg::KEY_OFFSET
                                        : mtkm_pkg::KEY_OFFSET + mtkm_pkg::KEY_W'(quo_step);
                    r_res <= '{result_kind: mtkm_pkg::KIND_LOAD, matched_tile: '0,
                               key_value: r_div_zero ? mtkm_pkg::KEY_OFFSET
                                   : mtkm_pkg::KEY_OFFSET + mtkm_pkg::KEY_W'(quo_step),
                               status: (r_entries >= TCW'(TABLE_ENTRIES)) ? mtkm_pkg::ST_FULL
                                                                         : mtkm_pkg::ST_OK};
                end
            end
            mtkm_pkg::S_INS_CMP: begin
                if (rd_gt) r_pos <= r_pos - TCW'(1);
            end
            mtkm_pkg::S_SRCH_CMP: begin
                if (rd_key <= r_key) r_lo <= mid + TCW'(1);
                else r_hi <= mid;
            end
            mtkm_pkg::S_PICK_WAIT: begin
                r_res.matched_tile <= ram_rdata[mtkm_pkg::ID_W-1:0];
            end
            mtkm_pkg::S_EMIT: begin
                if (out_free) r_out <= r_res;
            end
            default: r_out <= r_out;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= TCW'(TABLE_ENTRIES))
        else $error("table count beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.operation == mtkm_pkg::OP_CLEAR) |=> (r_entries == '0))
        else $error("clear did not empty table");

    a_full_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == mtkm_pkg::ST_FULL)
            |-> (o_out_word.result_kind == mtkm_pkg::KIND_LOAD))
        else $error("full status on a query word");

    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.operation == mtkm_pkg::OP_QUERY && r_entries == '0)
            |=> (r_state == mtkm_pkg::S_EMIT))
        else $error("empty-table query did not go straight to result");

endmodule
